/* sv/lrc_pkg.sv */
package lrc_pkg;

    // record framing
    localparam int HEADER_BYTES       = 24;
    localparam int HDR_IDX_BITS       = $clog2(HEADER_BYTES);
    localparam int TRAILER_LEN        = 4;
    localparam int MIN_RECORD         = HEADER_BYTES + TRAILER_LEN;
    localparam int COUNT_BITS_DEFAULT = 32;
    localparam int SUM_BITS           = 34;
    localparam int VOFF_BITS          = 33;

    // crc-32c, reflected
    localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // status codes
    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_SHORT     = 3'd1;
    localparam logic [2:0] STATUS_BAD_MAGIC = 3'd2;
    localparam logic [2:0] STATUS_LENGTH    = 3'd3;
    localparam logic [2:0] STATUS_CRC       = 3'd4;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [31:0] record_magic;
        logic [15:0] family_id;
        logic [7:0]  record_type;
        logic [7:0]  record_flags;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic [63:0] sequence_res;
    } header_t;

    // one finished record as handed from front to back
    typedef struct packed {
        header_t     header;
        logic [31:0] crc;
        logic [31:0] trailer;
    } record_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] record_magic;
        logic [15:0] family_id;
        logic [7:0]  record_type;
        logic [7:0]  record_flags;
        logic [31:0] key_length;
        logic [31:0] value_length;
        logic [63:0] sequence_res;
        logic [31:0] value_offset;
    } result_t;

    // one byte of crc-32c, bit by bit
    function automatic logic [31:0] crc_feed(input logic [31:0] crc_in,
                                             input logic [7:0] data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* sv/lrc_front.sv */
module lrc_front #(
    parameter int COUNT_BITS = lrc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    input  logic                                        q_full,
    input  lrc_pkg::in_item_t                           in_item,
    output logic                                        full,
    output logic                                        q_push,
    output logic [$bits(lrc_pkg::record_t)+COUNT_BITS-1:0] q_data
);

    localparam int IB = lrc_pkg::HDR_IDX_BITS;

    logic [COUNT_BITS-1:0] count_reg, count_next, count_inc;
    logic [31:0]           crc_reg, crc_next, crc_fed;
    logic [31:0]           trailer_reg, trailer_next, trailer_fed;
    logic [7:0]            header_reg [lrc_pkg::HEADER_BYTES];
    logic                  accept;
    lrc_pkg::record_t      rec;

    // byte intake stalls while the record queue is full
    assign full   = q_full;
    assign accept = push && !q_full;

    // per-byte update of count, crc and trailer window
    always_comb
    begin
        count_inc   = (&count_reg) ? count_reg : count_reg + COUNT_BITS'(1);
        crc_fed     = (count_reg >= COUNT_BITS'(lrc_pkg::TRAILER_LEN))
                      ? lrc_pkg::crc_feed(crc_reg, trailer_reg[7:0]) : crc_reg;
        trailer_fed = {in_item.data_byte, trailer_reg[31:8]};
        count_next   = count_reg;
        crc_next     = crc_reg;
        trailer_next = trailer_reg;
        if (accept)
        begin
            if (in_item.last_byte)
            begin
                count_next   = '0;
                crc_next     = lrc_pkg::CRC_INIT;
                trailer_next = '0;
            end
            else
            begin
                count_next   = count_inc;
                crc_next     = crc_fed;
                trailer_next = trailer_fed;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            crc_reg     <= lrc_pkg::CRC_INIT;
            trailer_reg <= '0;
        end
        else
        begin
            count_reg   <= count_next;
            crc_reg     <= crc_next;
            trailer_reg <= trailer_next;
        end
    end

    // header capture
    always_ff @(posedge clk)
    begin
        if (accept && count_reg < COUNT_BITS'(lrc_pkg::HEADER_BYTES))
            header_reg[count_reg[IB-1:0]] <= in_item.data_byte;
    end

    // little-endian header fields
    always_comb
    begin
        rec.header.record_magic = {header_reg[3], header_reg[2],
                                   header_reg[1], header_reg[0]};
        rec.header.family_id    = {header_reg[5], header_reg[4]};
        rec.header.record_type  = header_reg[6];
        rec.header.record_flags = header_reg[7];
        rec.header.key_length   = {header_reg[11], header_reg[10],
                                   header_reg[9], header_reg[8]};
        rec.header.value_length = {header_reg[15], header_reg[14],
                                   header_reg[13], header_reg[12]};
        rec.header.sequence_res = {header_reg[23], header_reg[22], header_reg[21],
                                   header_reg[20], header_reg[19], header_reg[18],
                                   header_reg[17], header_reg[16]};
        rec.crc     = crc_fed;
        rec.trailer = trailer_fed;
    end

    // hand the finished record to the queue
    assign q_push = accept && in_item.last_byte;
    assign q_data = {count_inc, rec};

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |=> (count_reg == '0 && crc_reg == lrc_pkg::CRC_INIT))
        else $error("record state not cleared after last byte");

endmodule

/* sv/lrc_queue.sv */
module lrc_queue #(
    parameter int DATA_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    output logic [DATA_BITS-1:0] rd_data,
    output logic                 q_full,
    output logic                 q_empty
);

    localparam int DEPTH  = lrc_pkg::QUEUE_DEPTH;
    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    logic [DATA_BITS-1:0] mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 do_wr, do_rd;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0
                              : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !q_full)
        else $error("write into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count out of range");

endmodule

/* sv/lrc_back.sv */
module lrc_back #(
    parameter int COUNT_BITS = lrc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        q_empty,
    input  logic [$bits(lrc_pkg::record_t)+COUNT_BITS-1:0] q_data,
    input  logic [31:0]                                 expected_magic,
    input  logic                                        pop,
    output logic                                        q_pop,
    output logic                                        empty,
    output lrc_pkg::result_t                            result
);

    localparam int CMP_BITS = (COUNT_BITS > lrc_pkg::SUM_BITS)
                              ? COUNT_BITS : lrc_pkg::SUM_BITS;

    lrc_pkg::record_t             rec;
    logic [COUNT_BITS-1:0]        count;
    logic [lrc_pkg::SUM_BITS-1:0] sum;
    logic [lrc_pkg::VOFF_BITS-1:0] voff;
    logic                         too_short, len_bad;
    lrc_pkg::result_t             res_comb;
    lrc_pkg::result_t             out_reg;
    logic                         out_valid_reg, out_valid_next;
    logic                         load;

    assign {count, rec} = q_data;

    // checks in priority order
    always_comb
    begin
        sum = lrc_pkg::SUM_BITS'(lrc_pkg::HEADER_BYTES)
            + lrc_pkg::SUM_BITS'(rec.header.key_length)
            + lrc_pkg::SUM_BITS'(rec.header.value_length)
            + lrc_pkg::SUM_BITS'(lrc_pkg::TRAILER_LEN);
        voff = lrc_pkg::VOFF_BITS'(lrc_pkg::HEADER_BYTES)
             + lrc_pkg::VOFF_BITS'(rec.header.key_length);
        too_short = count < COUNT_BITS'(lrc_pkg::MIN_RECORD);
        len_bad   = (&count) || (CMP_BITS'(count) != CMP_BITS'(sum));

        res_comb = '0;
        if (too_short)
            res_comb.status = lrc_pkg::STATUS_SHORT;
        else
        begin
            res_comb.record_magic = rec.header.record_magic;
            res_comb.family_id    = rec.header.family_id;
            res_comb.record_type  = rec.header.record_type;
            res_comb.record_flags = rec.header.record_flags;
            res_comb.key_length   = rec.header.key_length;
            res_comb.value_length = rec.header.value_length;
            res_comb.sequence_res = rec.header.sequence_res;
            res_comb.value_offset = voff[32] ? 32'hFFFF_FFFF : voff[31:0];
            if (rec.header.record_magic != expected_magic)
                res_comb.status = lrc_pkg::STATUS_BAD_MAGIC;
            else if (len_bad)
                res_comb.status = lrc_pkg::STATUS_LENGTH;
            else if ((rec.crc ^ 32'hFFFF_FFFF) != rec.trailer)
                res_comb.status = lrc_pkg::STATUS_CRC;
            else
                res_comb.status = lrc_pkg::STATUS_OK;
        end
    end

    // result register, refilled as soon as it is taken while the queue holds a record
    assign load  = !q_empty && (!out_valid_reg || pop);
    assign q_pop = load;
    assign empty = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= res_comb;
    end

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result changed while stalled");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.status <= lrc_pkg::STATUS_CRC))
        else $error("result status code out of range");

endmodule

/* sv/log_record_checker_core.sv */
// channel   direction  handshake            payload
// input     in         push / full          in_item  (data_byte, last_byte)
// result    out        pop / empty          result   (status .. value_offset)
// config    in         cfg_write            cfg_data (expected_magic)
//
// one byte per cycle while full is low; a record's result passes the queue and then the result register
// the front does the byte-wide crc-32c update, the back does the length add and the
// magic, length and crc compares into the result register; a two-entry queue sits between them
// reset clears byte count, crc, trailer window, queue and magic; header bytes
// are not reset
// full rises only when two records wait behind an untaken result
module log_record_checker_core #(
    parameter int COUNT_BITS = lrc_pkg::COUNT_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lrc_pkg::in_item_t in_item,
    output logic              empty,
    input  logic              pop,
    output lrc_pkg::result_t  result,
    input  logic              cfg_write,
    input  logic [31:0]       cfg_data
);

    localparam int ENTRY_BITS = $bits(lrc_pkg::record_t) + COUNT_BITS;

    logic [31:0]           magic_reg;
    logic                  q_push, q_pop, q_full, q_empty;
    logic [ENTRY_BITS-1:0] q_wr_data, q_rd_data;

    // expected magic register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_reg <= '0;
        else if (cfg_write)
            magic_reg <= cfg_data;
    end

    // byte intake, crc and header capture
    lrc_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .q_full  (q_full),
        .in_item (in_item),
        .full    (full),
        .q_push  (q_push),
        .q_data  (q_wr_data)
    );

    // finished records waiting for the checks
    lrc_queue #(
        .DATA_BITS(ENTRY_BITS)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr_data),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    // checks and result register
    lrc_back #(
        .COUNT_BITS(COUNT_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_rd_data),
        .expected_magic (magic_reg),
        .pop            (pop),
        .q_pop          (q_pop),
        .empty          (empty),
        .result         (result)
    );

endmodule
